[hw/rtl/aps_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package aps_pkg;

  localparam int DATA_W = 16;
  localparam int SLOT_W = 6;

  localparam logic [DATA_W-1:0] TIME_SLICE_RST = 16'd50;
  localparam logic [DATA_W-1:0] TICK_LIMIT_RST = 16'd10000;

  localparam logic signed [DATA_W-1:0] PRI_MAX = 16'sh7FFF;
  localparam logic signed [DATA_W-1:0] PRI_MIN = 16'sh8000;

  typedef enum logic [0:0] {
    ACT_LOAD = 1'b0,
    ACT_TICK = 1'b1
  } action_t;

  typedef enum logic [0:0] {
    REG_TIME_SLICE = 1'b0,
    REG_TICK_LIMIT = 1'b1
  } cfg_reg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // write the item's slot into the tables
    logic tick_start;  // clear the search state and the slot counter
    logic issue;       // read the slot under the counter and advance it
    logic upd_mode;    // reads in flight belong to the aging pass
    logic decide;      // settle the budget and restart the counter
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_done;    // every slot of the pass has been read
    logic pipe_busy;   // a read is still waiting to be processed
    logic found;       // an eligible task was seen in the search
  } status_t;

endpackage

`default_nettype wire

[hw/rtl/aps_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module aps_ctrl
  import aps_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire logic    action,
  input  wire status_t status,
  output cmd_t         cmd,
  output logic         busy,
  output logic         done
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   pass_end;

  assign pass_end = status.cnt_done && !status.pipe_busy;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    unique case (state)
      ST_IDLE: begin
        if (start && (action == ACT_LOAD)) begin
          cmd.load = 1'b1;
        end else if (start && (action == ACT_TICK)) begin
          cmd.tick_start = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.issue = !status.cnt_done;
        if (pass_end) begin
          state_next = status.found ? ST_DECIDE : ST_DONE;
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.issue    = !status.cnt_done;
        cmd.upd_mode = 1'b1;
        if (pass_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);

endmodule

`default_nettype wire

[hw/rtl/aps_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module aps_datapath
  import aps_pkg::*;
#(
  parameter int NUM_SLOTS = 64
)
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cmd_t                     cmd,
  output status_t                       status,
  input  wire logic [SLOT_W-1:0]        slot,
  input  wire logic signed [DATA_W-1:0] start_priority,
  input  wire logic [DATA_W-1:0]        need_time,
  input  wire logic                     cfg_we,
  input  wire logic                     cfg_index,
  input  wire logic [DATA_W-1:0]        cfg_data,
  output logic [SLOT_W-1:0]             chosen,
  output logic                          found,
  output logic                          ran,
  output logic                          finished,
  output logic [DATA_W-1:0]             ticks_used
);

  localparam int IW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 1);

  logic signed [DATA_W-1:0] pri_mem [NUM_SLOTS];
  logic [DATA_W-1:0]        rem_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]     active;

  logic [DATA_W-1:0] time_slice;
  logic [DATA_W-1:0] tick_limit;
  logic [DATA_W-1:0] serviced;

  logic [CW-1:0]            cnt;
  logic                     v_q;
  logic [IW-1:0]            addr_q;
  logic                     act_q;
  logic signed [DATA_W-1:0] pri_q;
  logic [DATA_W-1:0]        rem_q;

  logic [IW-1:0]            best;
  logic signed [DATA_W-1:0] best_pri;
  logic                     found_r;
  logic                     ran_r;
  logic                     fin_r;

  logic [8:0]               slot_wide;
  logic                     slot_ok;
  logic                     hit;
  logic                     is_best;
  logic                     rem_fin;
  logic signed [DATA_W-1:0] pri_inc;
  logic signed [DATA_W-1:0] pri_dec;
  logic                     pri_we;
  logic [IW-1:0]            pri_waddr;
  logic signed [DATA_W-1:0] pri_wdata;
  logic                     rem_we;
  logic [IW-1:0]            rem_waddr;
  logic [DATA_W-1:0]        rem_wdata;
  logic                     upd_best;
  logic                     scan_better;

  assign slot_wide = 9'(slot);
  assign slot_ok   = slot_wide < 9'(NUM_SLOTS);

  assign hit     = v_q && act_q;
  assign is_best = (addr_q == best);
  assign rem_fin = (rem_q <= time_slice);
  assign pri_inc = (pri_q == PRI_MAX) ? pri_q : pri_q + 16'sd1;
  assign pri_dec = (pri_q == PRI_MIN) ? pri_q : pri_q - 16'sd1;

  assign upd_best    = cmd.upd_mode && hit && is_best && ran_r;
  assign scan_better = !cmd.upd_mode && hit && (pri_q > best_pri);

  always_comb begin
    pri_we    = 1'b0;
    pri_waddr = addr_q;
    pri_wdata = pri_inc;
    rem_we    = 1'b0;
    rem_waddr = addr_q;
    rem_wdata = rem_fin ? '0 : rem_q - time_slice;
    if (cmd.load) begin
      pri_we    = slot_ok;
      pri_waddr = slot_wide[IW-1:0];
      pri_wdata = start_priority;
      rem_we    = slot_ok;
      rem_waddr = slot_wide[IW-1:0];
      rem_wdata = need_time;
    end else if (cmd.upd_mode && hit) begin
      if (!is_best) begin
        pri_we = 1'b1;
      end else if (ran_r) begin
        pri_we    = 1'b1;
        pri_wdata = pri_dec;
        rem_we    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pri_we) begin
      pri_mem[pri_waddr] <= pri_wdata;
    end
    pri_q <= pri_mem[cnt[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rem_we) begin
      rem_mem[rem_waddr] <= rem_wdata;
    end
    rem_q <= rem_mem[cnt[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    addr_q <= cnt[IW-1:0];
    act_q  <= active[cnt[IW-1:0]];
    if (scan_better || cmd.tick_start) begin
      best_pri <= scan_better ? pri_q : '0;
      best     <= scan_better ? addr_q : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= '0;
      time_slice <= TIME_SLICE_RST;
      tick_limit <= TICK_LIMIT_RST;
      serviced   <= '0;
      cnt        <= '0;
      v_q        <= 1'b0;
      found_r    <= 1'b0;
      ran_r      <= 1'b0;
      fin_r      <= 1'b0;
    end else begin
      v_q <= cmd.issue;
      if (cmd.tick_start || cmd.decide) begin
        cnt <= '0;
      end else if (cmd.issue) begin
        cnt <= cnt + CW'(1);
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TIME_SLICE: time_slice <= cfg_data;
          REG_TICK_LIMIT: tick_limit <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load && slot_ok) begin
        active[slot_wide[IW-1:0]] <= 1'b1;
      end
      if (upd_best && rem_fin) begin
        active[addr_q] <= 1'b0;
        fin_r          <= 1'b1;
      end
      if (cmd.tick_start) begin
        found_r <= 1'b0;
        ran_r   <= 1'b0;
        fin_r   <= 1'b0;
      end else if (scan_better) begin
        found_r <= 1'b1;
      end
      if (cmd.decide && (serviced < tick_limit)) begin
        ran_r    <= 1'b1;
        serviced <= serviced + 16'd1;
      end
    end
  end

  assign status.cnt_done  = (cnt == CW'(NUM_SLOTS));
  assign status.pipe_busy = v_q;
  assign status.found     = found_r;

  assign chosen     = SLOT_W'(best);
  assign found      = found_r;
  assign ran        = ran_r;
  assign finished   = fin_r;
  assign ticks_used = serviced;

endmodule

`default_nettype wire

[hw/rtl/aging_priority_scheduler_top.sv]
// A load item is absorbed in the idle state; busy stays low, so a new item may follow at once.
// A tick item makes one table read per slot in the search pass and, when an eligible task
// was found, again in the aging pass. Busy stays high until the tick is done, so the next
// item waits until the scheduler is back in the idle state.
// Reset (rst, synchronous, active high) clears every active flag and the serviced count
// and restores time_slice to 50 and tick_limit to 10000; the tables hold no reset value.
`timescale 1ns / 1ps
`default_nettype none

module aging_priority_scheduler_top
  import aps_pkg::*;
#(
  parameter int NUM_SLOTS = 64
)
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  // Item channel: a transfer happens when start is high and busy is low.
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic                     action,
  input  wire logic [SLOT_W-1:0]        slot,
  input  wire logic signed [DATA_W-1:0] start_priority,
  input  wire logic [DATA_W-1:0]        need_time,
  // Result channel: done marks a one-cycle transfer of the fields below.
  output logic                          done,
  output logic [SLOT_W-1:0]             chosen,
  output logic                          found,
  output logic                          ran,
  output logic                          finished,
  output logic [DATA_W-1:0]             ticks_used,
  // Configuration write channel.
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic                     cfg_index,
  input  wire logic [DATA_W-1:0]        cfg_data
);

  cmd_t    cmd;
  status_t status;

  // Registers are to be written by the user only while the scheduler is idle; the block does
  // not enforce this. cfg_ready is tied high, so the channel can always take a transfer.
  assign cfg_ready = 1'b1;

  // The controller sequences a tick as a search pass over all slots, a budget
  // decision and, when a task was found, an aging pass that rewrites every other active
  // slot and the chosen one if it ran; loads are absorbed in the idle state.
  aps_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // The datapath owns both task tables, the active flags, the configuration
  // registers and the serviced-tick counter. Results stay registered until
  // the next tick begins, so they are stable in the cycle that done marks.
  aps_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .slot           (slot),
    .start_priority (start_priority),
    .need_time      (need_time),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .chosen         (chosen),
    .found          (found),
    .ran            (ran),
    .finished       (finished),
    .ticks_used     (ticks_used)
  );

endmodule

`default_nettype wire

[hw/rtl/aps_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module aps_checker
  import aps_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     start,
  input wire logic                     busy,
  input wire logic                     action,
  input wire logic [SLOT_W-1:0]        slot,
  input wire logic signed [DATA_W-1:0] start_priority,
  input wire logic [DATA_W-1:0]        need_time,
  input wire logic                     done,
  input wire logic [SLOT_W-1:0]        chosen,
  input wire logic                     found,
  input wire logic                     ran,
  input wire logic                     finished,
  input wire logic [DATA_W-1:0]        ticks_used,
  input wire logic                     cfg_valid,
  input wire logic                     cfg_ready,
  input wire logic                     cfg_index,
  input wire logic [DATA_W-1:0]        cfg_data
);

  // A load transfer never blocks the next item.
  a_load_no_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (action == ACT_LOAD)) |=> !busy)
    else $error("load transfer made the scheduler busy");

  // A tick transfer always occupies the scheduler on the next cycle.
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (action == ACT_TICK)) |=> busy)
    else $error("tick transfer did not start work");

  // A result appears only while a tick is in progress.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe outside a tick");

  // Without an eligible task nothing runs and slot zero is reported.
  a_not_found: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (!ran && !finished && (chosen == '0)))
    else $error("empty tick reported service");

  // A task can only finish on a tick in which it ran.
  a_finish_ran: assert property (@(posedge clk) disable iff (rst)
    (done && finished) |-> (ran && found))
    else $error("task finished without service");

endmodule

bind aging_priority_scheduler_top aps_checker u_aps_checker (.*);

`default_nettype wire

[test/aging_priority_scheduler_top_tb.sv]
`timescale 1ns / 1ps

module aging_priority_scheduler_top_tb;
  import aps_pkg::*;

  // The block is built with its default table size, so the scoreboard uses the same value.
  localparam int NUM_SLOTS = 64;
  // A tick keeps the block busy for up to two passes over the table plus its control
  // states. The block is idle again in the cycle after its result strobe.
  localparam int TICK_CYCLES = 2 * NUM_SLOTS + 6;
  // About 1600 items, each taking at most TICK_CYCLES plus the longest idle burst,
  // fit well within this limit, which leaves a wide margin.
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DIR_ROWS = 23;

  // One tick outcome, laid out like the block's result ports.
  typedef struct packed {
    logic [SLOT_W-1:0] chosen;
    logic              found;
    logic              ran;
    logic              finished;
    logic [DATA_W-1:0] ticks_used;
  } tick_outcome_t;

  // One scheduler command. When typed is set, want holds a hand-written outcome that
  // replaces the scoreboard's own prediction for that tick.
  typedef struct packed {
    action_t                  act;
    logic [SLOT_W-1:0]        slot;
    logic signed [DATA_W-1:0] pri;
    logic [DATA_W-1:0]        need;
    logic                     typed;
    tick_outcome_t            want;
  } sched_cmd_t;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic                     action;
  logic [SLOT_W-1:0]        slot;
  logic signed [DATA_W-1:0] start_priority;
  logic [DATA_W-1:0]        need_time;
  logic                     done;
  logic [SLOT_W-1:0]        chosen;
  logic                     found;
  logic                     ran;
  logic                     finished;
  logic [DATA_W-1:0]        ticks_used;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic                     cfg_index;
  logic [DATA_W-1:0]        cfg_data;

  aging_priority_scheduler_top #(
    .NUM_SLOTS(NUM_SLOTS)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .slot          (slot),
    .start_priority(start_priority),
    .need_time     (need_time),
    .done          (done),
    .chosen        (chosen),
    .found         (found),
    .ran           (ran),
    .finished      (finished),
    .ticks_used    (ticks_used),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 4 ns clock period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Scoreboard copy of the scheduler state. It is updated at the clock edge where
  // the block accepts each transfer, so it always matches what the block has seen.
  // ---------------------------------------------------------------------------
  logic signed [DATA_W-1:0] prio_tab [NUM_SLOTS];
  logic [DATA_W-1:0]        left_tab [NUM_SLOTS];
  bit                       live     [NUM_SLOTS];
  logic [DATA_W-1:0]        serviced_q;
  logic [DATA_W-1:0]        slice_q;
  logic [DATA_W-1:0]        limit_q;

  tick_outcome_t outcome_q [$];

  int mismatch_count = 0;
  int cycle_count = 0;
  int loads_sent = 0;
  int ticks_sent = 0;
  int results_seen = 0;
  int found_seen = 0;
  int ran_seen = 0;
  int finished_seen = 0;
  int spent_seen = 0;

  function automatic void load_slot_model(input logic [SLOT_W-1:0] s,
                                          input logic signed [DATA_W-1:0] p,
                                          input logic [DATA_W-1:0] n);
    // With 64 slots every 6-bit index is in range, so a load is never dropped.
    prio_tab[s] = p;
    left_tab[s] = n;
    live[s] = 1'b1;
  endfunction

  // Picks the highest strictly positive priority. Because the compare is strict and
  // the scan goes upward, the lowest index wins a tie. The chosen task runs only if
  // the budget allows it. When a task is found, every other live task ages by one,
  // saturating at PRI_MAX, even when the budget is spent.
  function automatic tick_outcome_t run_tick_model();
    tick_outcome_t r;
    int best;
    logic signed [DATA_W-1:0] best_pri;
    r = '0;
    best = 0;
    best_pri = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (live[i] && prio_tab[i] > best_pri) begin
        best_pri = prio_tab[i];
        best = i;
        r.found = 1'b1;
      end
    end
    if (r.found) begin
      r.chosen = SLOT_W'(best);
      if (serviced_q < limit_q) begin
        r.ran = 1'b1;
        serviced_q = serviced_q + 1'b1;
        // The remaining time clamps at zero, and reaching zero retires the task.
        if (left_tab[best] <= slice_q) begin
          left_tab[best] = '0;
          live[best] = 1'b0;
          r.finished = 1'b1;
        end else begin
          left_tab[best] = left_tab[best] - slice_q;
        end
        if (prio_tab[best] != PRI_MIN) prio_tab[best] = prio_tab[best] - 1'b1;
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (i != best && live[i] && prio_tab[i] != PRI_MAX)
          prio_tab[i] = prio_tab[i] + 1'b1;
      end
    end
    r.ticks_used = serviced_q;
    return r;
  endfunction

  function automatic int live_count();
    int n;
    n = 0;
    for (int i = 0; i < NUM_SLOTS; i++) n += live[i];
    return n;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker. The result ports are sampled at the rising edge, which gives
  // their values from before that edge. Every strobe must match the oldest
  // pending expectation, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    tick_outcome_t want;
    if (!rst && done) begin
      results_seen++;
      if (outcome_q.size() == 0) begin
        report_mismatch("result strobe with nothing pending", 1, 0);
      end else begin
        want = outcome_q.pop_front();
        if (chosen !== want.chosen) report_mismatch("chosen", chosen, want.chosen);
        if (found !== want.found) report_mismatch("found", found, want.found);
        if (ran !== want.ran) report_mismatch("ran", ran, want.ran);
        if (finished !== want.finished) report_mismatch("finished", finished, want.finished);
        if (ticks_used !== want.ticks_used)
          report_mismatch("ticks_used", ticks_used, want.ticks_used);
        found_seen += want.found;
        ran_seen += want.ran;
        finished_seen += want.finished;
        spent_seen += (want.found && !want.ran);
      end
    end
  end

  // The watchdog stops a hung run. Leftover expectations also end up here, because
  // the final drain never finishes when results are missing.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("aging_priority_scheduler_top_tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. Inputs change on the falling edge. A transfer is detected at the
  // rising edge where busy (as sampled before that edge) is low.
  // ---------------------------------------------------------------------------
  task automatic issue_cmd(input sched_cmd_t c);
    tick_outcome_t pred;
    @(negedge clk);
    start = 1'b1;
    action = c.act;
    slot = c.slot;
    start_priority = c.pri;
    need_time = c.need;
    do @(posedge clk); while (busy);
    if (c.act == ACT_LOAD) begin
      load_slot_model(c.slot, c.pri, c.need);
      loads_sent++;
    end else begin
      pred = run_tick_model();
      outcome_q.push_back(c.typed ? c.want : pred);
      ticks_sent++;
    end
  endtask

  // Holds the sender off until every pending tick has reported.
  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
  endtask

  // A load has no result and never makes the block busy, so the block is idle once
  // the last strobe has been seen. The extra tick time before touching its registers
  // is only a margin.
  task automatic settle_block();
    drain_results();
    repeat (TICK_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_reg_t idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_TIME_SLICE) slice_q = val;
    else limit_q = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Random traffic. When few tasks are live, loads are favored so that ticks
  // mostly find real work. Priorities and needs are biased toward saturation,
  // exact-slice and zero cases, and sometimes take fully random values so that
  // every field bit toggles.
  function automatic sched_cmd_t random_cmd();
    sched_cmd_t c;
    int load_pct;
    c = '0;
    c.slot = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
    c.pri = DATA_W'($urandom);
    c.need = DATA_W'($urandom);
    load_pct = (live_count() < 4) ? 70 : 30;
    if ($urandom_range(0, 99) < load_pct) begin
      c.act = ACT_LOAD;
      case ($urandom_range(0, 9))
        0: c.pri = DATA_W'($urandom);
        1: c.pri = PRI_MAX - DATA_W'($urandom_range(0, 3));
        2: c.pri = PRI_MIN + DATA_W'($urandom_range(0, 3));
        3: c.pri = DATA_W'(-int'($urandom_range(0, 5)));
        default: c.pri = DATA_W'($urandom_range(1, 300));
      endcase
      case ($urandom_range(0, 9))
        0: c.need = DATA_W'($urandom);
        1: c.need = '0;
        2: c.need = '1;
        3: c.need = slice_q;
        4: c.need = slice_q + 1'b1;
        default: c.need = DATA_W'($urandom_range(1, 400));
      endcase
    end else begin
      // The payload fields of a tick are don't-care, so they stay random.
      c.act = ACT_TICK;
    end
    return c;
  endfunction

  // Runs count random commands. When idle_ok is set, the sender inserts idle bursts
  // of random length now and then, with long stretches of back-to-back traffic
  // in between. Halfway through, the sender waits until nothing is pending.
  task automatic run_phase(input int count, input bit idle_ok);
    for (int n = 0; n < count; n++) begin
      if (idle_ok && $urandom_range(0, 7) == 0) begin
        @(negedge clk);
        start = 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      if (n == count / 2) drain_results();
      issue_cmd(random_cmd());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed commands at the reset settings (slice 50, limit 10000). Outcomes are
  // written out by hand only where they are obvious: an empty table, a table
  // with nothing eligible, and a lone top-priority task that needs no time.
  // ---------------------------------------------------------------------------
  sched_cmd_t directed_rows [DIR_ROWS];

  initial begin
    directed_rows = '{
      // No task has been loaded yet, so nothing is found and nothing ages.
      '{ACT_TICK, 6'd0,  16'sh0000, 16'h0000, 1'b1, '{6'd0, 1'b0, 1'b0, 1'b0, 16'd0}},
      '{ACT_LOAD, 6'd0,  16'sh8000, 16'hFFFF, 1'b0, '0},
      '{ACT_LOAD, 6'd1,  16'sh0000, 16'd10,   1'b0, '0},
      // Live tasks with zero or most-negative priority are not eligible.
      '{ACT_TICK, 6'd0,  16'sh0000, 16'h0000, 1'b1, '{6'd0, 1'b0, 1'b0, 1'b0, 16'd0}},
      '{ACT_LOAD, 6'd63, 16'sh7FFF, 16'h0000, 1'b0, '0},
      // The top slot wins and finishes at once, because it needs no time.
      '{ACT_TICK, 6'd0,  16'sh0000, 16'h0000, 1'b1, '{6'd63, 1'b1, 1'b1, 1'b1, 16'd1}},
      // Slot 1 has aged from zero to one and now becomes eligible.
      '{ACT_TICK, 6'd0,  16'sh0000, 16'h0000, 1'b0, '0},
      // Two tasks tie at the maximum priority; the lower index must win.
      '{ACT_LOAD, 6'd5,  16'sh7FFF, 16'hFFFF, 1'b0, '0},
      '{ACT_LOAD, 6'd6,  16'sh7FFF, 16'd200,  1'b0, '0},
      '{ACT_TICK, 6'd0,  16'sh0000, 16'h0000, 1'b0, '0},
      '{ACT_TICK, 6'd0,  16'sh0000, 16'h0000, 1'b0, '0},
      // Reloading a live slot replaces it. A need equal to the slice finishes in one
      // run; a need one above it takes two.
      '{ACT_LOAD, 6'd5,  16'sh0001, 16'd50,   1'b0, '0},
      '{ACT_LOAD, 6'd2,  16'sh0064, 16'd51,   1'b0, '0},
      '{ACT_TICK, 6'd0,  16'sh0000, 16'h0000, 1'b0, '0},
      '{ACT_TICK, 6'd0,  16'sh0000, 16'h0000, 1'b0, '0},
      '{ACT_TICK, 6'd0,  16'sh0000, 16'h0000, 1'b0, '0},
      '{ACT_TICK, 6'd0,  16'sh0000, 16'h0000, 1'b0, '0},
      '{ACT_TICK, 6'd0,  16'sh0000, 16'h0000, 1'b0, '0},
      // Alternating bit patterns on every payload field.
      '{ACT_LOAD, 6'd42, 16'sh5555, 16'hAAAA, 1'b0, '0},
      '{ACT_LOAD, 6'd21, 16'shAAAA, 16'h5555, 1'b0, '0},
      '{ACT_TICK, 6'd21, 16'shAAAA, 16'hAAAA, 1'b0, '0},
      '{ACT_TICK, 6'd42, 16'sh5555, 16'h5555, 1'b0, '0},
      '{ACT_TICK, 6'd63, 16'shFFFF, 16'hFFFF, 1'b0, '0}
    };
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, the directed commands, then random phases under
  // different register settings. The settings cover the slice and limit
  // extremes, a zero slice, and a budget that runs out partway through a phase.
  // The last phase has no idle cycles.
  // ---------------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    start = 1'b0;
    action = ACT_LOAD;
    slot = '0;
    start_priority = '0;
    need_time = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_TIME_SLICE;
    cfg_data = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      prio_tab[i] = '0;
      left_tab[i] = '0;
      live[i] = 1'b0;
    end
    serviced_q = '0;
    slice_q = TIME_SLICE_RST;
    limit_q = TICK_LIMIT_RST;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) issue_cmd(directed_rows[i]);

    // Random traffic at the reset settings.
    run_phase(300, 1'b1);

    // Smallest slice with the largest budget: tasks run for a long time.
    settle_block();
    write_cfg(REG_TIME_SLICE, 16'd1);
    write_cfg(REG_TICK_LIMIT, 16'hFFFF);
    run_phase(300, 1'b1);

    // Largest slice, so every run finishes its task. The budget runs out a few
    // dozen ticks in, and after that only aging goes on.
    settle_block();
    write_cfg(REG_TIME_SLICE, 16'hFFFF);
    write_cfg(REG_TICK_LIMIT, serviced_q + 16'd25);
    run_phase(300, 1'b1);

    // Zero slice: only tasks loaded with zero need can finish.
    settle_block();
    write_cfg(REG_TIME_SLICE, 16'd0);
    write_cfg(REG_TICK_LIMIT, 16'hFFFF);
    run_phase(150, 1'b1);

    // Zero budget: every tick that finds a task reports it as not serviced.
    settle_block();
    write_cfg(REG_TIME_SLICE, DATA_W'($urandom_range(1, 500)));
    write_cfg(REG_TICK_LIMIT, 16'd0);
    run_phase(150, 1'b1);

    // Final stretch at full rate.
    settle_block();
    write_cfg(REG_TIME_SLICE, DATA_W'($urandom_range(20, 300)));
    write_cfg(REG_TICK_LIMIT, 16'hFFFF);
    run_phase(400, 1'b0);

    drain_results();
    repeat (TICK_CYCLES) @(posedge clk);

    $display("Ran %0d loads and %0d ticks over six register settings; %0d results checked.",
             loads_sent, ticks_sent, results_seen);
    $display("Ticks that found a task: %0d, serviced: %0d, completed: %0d, over budget: %0d.",
             found_seen, ran_seen, finished_seen, spent_seen);
    if (mismatch_count == 0) begin
      $display("aging_priority_scheduler_top_tb: clean");
    end else begin
      $display("aging_priority_scheduler_top_tb: errors");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/aps_pkg.sv
hw/rtl/aps_ctrl.sv
hw/rtl/aps_datapath.sv
hw/rtl/aging_priority_scheduler_top.sv
hw/rtl/aps_checker.sv
test/aging_priority_scheduler_top_tb.sv
